[rtl/colour_sequence_dedupe_and_gap_fill_defines.svh]
// ----------------------------------------------------------------------------
// Colour sequence dedupe and gap fill: assertion macros
// Property macros for the checks in the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef COLOUR_SEQUENCE_DEDUPE_AND_GAP_FILL_DEFINES_SVH
`define COLOUR_SEQUENCE_DEDUPE_AND_GAP_FILL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CSDGF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSDGF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/csdgf_pkg.sv]
// ----------------------------------------------------------------------------
// Colour sequence dedupe and gap fill: package
// Types, codes and the colour index successor function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csdgf_pkg;

    // Video system codes.
    localparam logic [2:0] SYS_UNKNOWN = 3'd0;
    localparam logic [2:0] SYS_PAL     = 3'd1;
    localparam logic [2:0] SYS_PALM    = 3'd2;
    localparam logic [2:0] SYS_NTSC    = 3'd3;
    localparam logic [2:0] SYS_OTHER   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEDUPE   = 2'd0;
    localparam logic [1:0] CFG_GAP_FILL = 2'd1;
    localparam logic [1:0] CFG_SYSTEM   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_EMIT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic load_pad;
        logic load_final;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic drop;
        logic gap_needed;
        logic pad_done;
        logic out_free;
    } ctrl_sts_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] idx;
    } succ_t;

    // Next colour index in the sequence; valid is low when there is none.
    function automatic succ_t successor(logic [2:0] sys, logic valid, logic [3:0] idx);
        succ_t r;
        r.valid = 1'b0;
        r.idx   = 4'd0;
        if (valid)
        begin
            case (sys)
                SYS_PAL, SYS_PALM:
                begin
                    r.valid = 1'b1;
                    r.idx   = {2'b00, idx[1:0]} + 4'd1;
                end
                SYS_NTSC:
                begin
                    if (idx <= 4'd1)
                    begin
                        r.valid = 1'b1;
                        r.idx   = 4'd1 - idx;
                    end
                end
                default:
                begin
                    r.valid = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

endpackage

[rtl/csdgf_datapath.sv]
// ----------------------------------------------------------------------------
// Colour sequence dedupe and gap fill: datapath
// Holds configuration, sequence state, the current item, the pad generator
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csdgf_datapath #(
    parameter int MAX_GAP_FILL = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  csdgf_pkg::ctrl_cmd_t   cmd,
    output csdgf_pkg::ctrl_sts_t   sts,
    input  logic [1:0]             s_tuser,
    input  logic [39:0]            s_tdata,
    input  logic                   cfg_valid,
    input  logic [1:0]             cfg_index,
    input  logic [2:0]             cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [71:0]            m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);
    import csdgf_pkg::*;

    localparam int CntW = $clog2(MAX_GAP_FILL + 1);

    // Input beat fields.
    logic        in_start;
    logic        in_pad;
    logic [31:0] in_frame;
    logic        in_known;
    logic [3:0]  in_cidx;

    assign in_start = s_tuser[0];
    assign in_pad   = s_tuser[1];
    assign in_frame = s_tdata[31:0];
    assign in_known = s_tdata[32];
    assign in_cidx  = s_tdata[36:33];

    // Configuration registers.
    logic       dedupe_reg;
    logic       gap_fill_reg;
    logic [2:0] system_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dedupe_reg   <= 1'b0;
            gap_fill_reg <= 1'b0;
            system_reg   <= SYS_UNKNOWN;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEDUPE:   dedupe_reg   <= cfg_data[0];
                CFG_GAP_FILL: gap_fill_reg <= cfg_data[0];
                CFG_SYSTEM:   system_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Sequence state and item registers.
    logic            have_prev_reg, have_prev_next;
    logic            prev_known_reg, prev_known_next;
    logic [3:0]      prev_idx_reg, prev_idx_next;
    logic [31:0]     pos_reg, pos_next;
    logic            item_pad_reg;
    logic [31:0]     item_frame_reg;
    logic            item_known_reg;
    logic [3:0]      item_cidx_reg;
    logic [3:0]      fill_reg, fill_next;
    logic            fill_valid_reg, fill_valid_next;
    logic [CntW-1:0] count_reg, count_next;

    // State as seen by the arriving beat, after a start-of-list clear.
    logic       eff_have_prev;
    logic       eff_prev_known;
    logic [3:0] eff_prev_idx;
    logic       comparable;
    logic       sys_fills;
    succ_t      first_succ;
    succ_t      pad_succ;

    assign eff_have_prev  = have_prev_reg & ~in_start;
    assign eff_prev_known = prev_known_reg & ~in_start;
    assign eff_prev_idx   = in_start ? 4'd0 : prev_idx_reg;
    assign comparable     = in_known & eff_have_prev & eff_prev_known;
    assign sys_fills      = (system_reg == SYS_PAL) || (system_reg == SYS_PALM) ||
                            (system_reg == SYS_NTSC) || (system_reg == SYS_OTHER);
    assign first_succ     = successor(system_reg, 1'b1, eff_prev_idx);
    assign pad_succ       = successor(system_reg, fill_valid_reg, fill_reg);

    // Decision for the arriving beat; padding slots never drop or fill.
    always_comb
    begin
        sts.drop       = ~in_pad & dedupe_reg & comparable & (eff_prev_idx == in_cidx);
        sts.gap_needed = ~in_pad & gap_fill_reg & comparable & sys_fills &
                         (~first_succ.valid | (first_succ.idx != in_cidx));
        sts.pad_done   = (count_reg == CntW'(MAX_GAP_FILL - 1)) ||
                         (pad_succ.valid && (pad_succ.idx == item_cidx_reg));
        sts.out_free   = ~m_tvalid | m_tready;
    end

    // Next state of the sequence and pad generator.
    always_comb
    begin
        have_prev_next  = have_prev_reg;
        prev_known_next = prev_known_reg;
        prev_idx_next   = prev_idx_reg;
        pos_next        = pos_reg;
        fill_next       = fill_reg;
        fill_valid_next = fill_valid_reg;
        count_next      = count_reg;
        if (cmd.accept)
        begin
            have_prev_next  = eff_have_prev;
            prev_known_next = eff_prev_known;
            prev_idx_next   = eff_prev_idx;
            pos_next        = in_start ? 32'd0 : pos_reg;
            fill_next       = first_succ.idx;
            fill_valid_next = first_succ.valid;
            count_next      = '0;
        end
        else if (cmd.load_pad)
        begin
            pos_next        = pos_reg + 32'd1;
            fill_next       = pad_succ.idx;
            fill_valid_next = pad_succ.valid;
            count_next      = count_reg + CntW'(1);
        end
        else if (cmd.load_final)
        begin
            pos_next        = pos_reg + 32'd1;
            have_prev_next  = 1'b1;
            prev_known_next = ~item_pad_reg & item_known_reg;
            if (!item_pad_reg)
            begin
                prev_idx_next = item_known_reg ? item_cidx_reg : 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg  <= 1'b0;
            prev_known_reg <= 1'b0;
            prev_idx_reg   <= 4'd0;
            pos_reg        <= 32'd0;
            fill_reg       <= 4'd0;
            fill_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            have_prev_reg  <= have_prev_next;
            prev_known_reg <= prev_known_next;
            prev_idx_reg   <= prev_idx_next;
            pos_reg        <= pos_next;
            fill_reg       <= fill_next;
            fill_valid_reg <= fill_valid_next;
            count_reg      <= count_next;
        end
    end

    // Capture the accepted beat.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_pad_reg   <= in_pad;
            item_frame_reg <= in_frame;
            item_known_reg <= in_known;
            item_cidx_reg  <= in_cidx;
        end
    end

    // Output register.
    logic        out_valid_reg;
    logic        out_pad_reg;
    logic        out_gap_reg;
    logic [31:0] out_frame_reg;
    logic [3:0]  out_cidx_reg;
    logic        out_ivalid_reg;
    logic [31:0] out_pos_reg;
    logic        out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_pad || cmd.load_final)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pad)
        begin
            out_pad_reg    <= 1'b1;
            out_gap_reg    <= 1'b1;
            out_frame_reg  <= 32'd0;
            out_cidx_reg   <= fill_valid_reg ? fill_reg : 4'd0;
            out_ivalid_reg <= fill_valid_reg;
            out_pos_reg    <= pos_reg;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.load_final)
        begin
            out_pad_reg    <= item_pad_reg;
            out_gap_reg    <= 1'b0;
            out_frame_reg  <= item_pad_reg ? 32'd0 : item_frame_reg;
            out_cidx_reg   <= (~item_pad_reg & item_known_reg) ? item_cidx_reg : 4'd0;
            out_ivalid_reg <= ~item_pad_reg & item_known_reg;
            out_pos_reg    <= pos_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_pos_reg, out_ivalid_reg, out_cidx_reg, out_frame_reg};
    assign m_tuser  = {out_gap_reg, out_pad_reg};
    assign m_tlast  = out_last_reg;

endmodule

[rtl/csdgf_ctrl.sv]
// ----------------------------------------------------------------------------
// Colour sequence dedupe and gap fill: controller
// Sequences accept, gap pad beats and the final beat of each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "colour_sequence_dedupe_and_gap_fill_defines.svh"

module csdgf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  csdgf_pkg::ctrl_sts_t   sts,
    output csdgf_pkg::ctrl_cmd_t   cmd
);
    import csdgf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !sts.drop)
                begin
                    state_next = sts.gap_needed ? ST_PAD : ST_EMIT;
                end
            end
            ST_PAD:
            begin
                if (sts.out_free && sts.pad_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        s_tready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.load_pad   = 1'b0;
        cmd.load_final = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_PAD:
            begin
                cmd.load_pad = sts.out_free;
            end
            ST_EMIT:
            begin
                cmd.load_final = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Checks on the sequencing.
    `CSDGF_ASSERT_NOW(a_one_load, 1'b1, !(cmd.load_pad && cmd.load_final), "two loads at once")
    `CSDGF_ASSERT_NEXT(a_final_idle, cmd.load_final, state_reg == ST_IDLE, "no return to idle")
    `CSDGF_ASSERT_NEXT(a_drop_idle, cmd.accept && sts.drop, state_reg == ST_IDLE, "drop emitted")
    `CSDGF_ASSERT_NEXT(a_gap_pad, cmd.accept && !sts.drop && sts.gap_needed,
        state_reg == ST_PAD, "gap without pads")

endmodule

[rtl/colour_sequence_dedupe_and_gap_fill.sv]
// ----------------------------------------------------------------------------
// Colour sequence dedupe and gap fill: top level
// Drops repeated colour frames and inserts pad entries where the colour
// frame index sequence skips, numbering every emitted entry.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  s_*      in         tuser: sequence_start, pad_slot; tdata: frame, index
//  m_*      out        tuser: padding, gap fill; tdata: frame, index, position
//  cfg_*    in         register index and write data, always ready
//
//  An item is accepted in ST_IDLE, then each result beat is loaded in turn;
//  a kept entry has at most MAX_GAP_FILL gap pads before its final beat, a
//  dropped entry is done at its accept. The pad generator emits one beat per
//  cycle; a stall on m_tready holds it. The last beat of an item may wait in
//  the output register while the next item is accepted. Reset clears all
//  but the item and output data registers; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module colour_sequence_dedupe_and_gap_fill #(
    parameter int MAX_GAP_FILL = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // source_frame[31:0], index_known[32], colour_index[36:33]
    input  logic [1:0]  s_tuser,   // sequence_start[0], pad_slot[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_frame[31:0], out_colour_index[35:32],
                                   // out_index_valid[36], out_position[68:37]
    output logic [1:0]  m_tuser,   // out_is_padding[0], out_gap_fill[1]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data
);
    import csdgf_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    csdgf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    csdgf_datapath #(
        .MAX_GAP_FILL (MAX_GAP_FILL)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[sim/colour_sequence_dedupe_and_gap_fill_tb.sv]
// ----------------------------------------------------------------------------
// Colour sequence dedupe and gap fill: testbench
// Drives frame entries into the block and checks every output beat against
// a cycle-free predictor. The predictor tracks the last kept entry, the
// output position and the three settings. A directed part covers drops,
// pad slots, unknown indices, every video system and runs that never reach
// the next index. A random part then sends well-formed colour index runs
// with skips, repeats, pad slots and unknown entries mixed in. Both stream
// sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module colour_sequence_dedupe_and_gap_fill_tb;

    import csdgf_pkg::*;

    localparam int GAP_LIMIT = 8;

    // One output beat as the block should present it.
    typedef struct packed {
        logic        padded;
        logic        gap_fill;
        logic [31:0] frame;
        logic [3:0]  colour_index;
        logic        index_valid;
        logic [31:0] position;
        logic        last;
    } frame_entry_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // source_frame[31:0], index_known[32], colour_index[36:33]
    logic [1:0]  s_tuser;   // sequence_start[0], pad_slot[1]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // out_frame[31:0], out_colour_index[35:32],
                            // out_index_valid[36], out_position[68:37]
    logic [1:0]  m_tuser;   // out_is_padding[0], out_gap_fill[1]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [2:0]  cfg_data;

    // Settings as last written.
    bit          dedupe_on;
    bit          gap_fill_on;
    bit [2:0]    system_sel;

    // Last kept entry and the running output position.
    bit          seen_entry;
    bit          last_real_known;
    bit [3:0]    last_index;
    bit [31:0]   out_count;

    frame_entry_t expected_entries[$];
    int          mismatches;
    bit          tx_idling;
    bit          rx_idling;

    colour_sequence_dedupe_and_gap_fill #(
        .MAX_GAP_FILL (GAP_LIMIT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Next colour index in the cycle of the current system; 0 when there is none.
    function automatic bit next_index(input bit valid, input int idx, output int nxt);
        nxt = 0;
        if (!valid || idx < 0)
            return 1'b0;
        if (system_sel == SYS_PAL || system_sel == SYS_PALM)
        begin
            nxt = (idx % 4) + 1;
            return 1'b1;
        end
        if (system_sel == SYS_NTSC && idx <= 1)
        begin
            nxt = 1 - idx;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Queue one expected beat and advance the output position.
    function automatic void push_entry(input bit pad, input bit gap, input bit [31:0] frame,
                                       input bit [3:0] idx, input bit valid, input bit last);
        frame_entry_t e;
        e.padded       = pad;
        e.gap_fill     = gap;
        e.frame        = frame;
        e.colour_index = valid ? idx : 4'd0;
        e.index_valid  = valid;
        e.position     = out_count;
        e.last         = last;
        expected_entries.insert(expected_entries.size(), e);
        out_count = out_count + 32'd1;
    endfunction

    // Work out the beats caused by one accepted entry.
    function automatic void predict_entry(input bit start, input bit pad, input bit [31:0] frame,
                                          input bit known, input bit [3:0] cidx);
        bit comparable;
        bit fill_valid;
        int fill;
        int nx;
        int count;
        if (start)
        begin
            seen_entry      = 1'b0;
            last_real_known = 1'b0;
            last_index      = 4'd0;
            out_count       = 32'd0;
        end
        if (pad)
        begin
            push_entry(1'b1, 1'b0, 32'd0, 4'd0, 1'b0, 1'b1);
            seen_entry      = 1'b1;
            last_real_known = 1'b0;
            return;
        end
        comparable = known && seen_entry && last_real_known;
        if (dedupe_on && comparable && last_index == cidx)
            return;
        if (gap_fill_on && comparable && system_sel >= SYS_PAL && system_sel <= SYS_OTHER)
        begin
            fill_valid = next_index(1'b1, int'(last_index), fill);
            if (!fill_valid || fill != int'(cidx))
            begin
                count = 0;
                while (count < GAP_LIMIT)
                begin
                    push_entry(1'b1, 1'b1, 32'd0, fill_valid ? fill[3:0] : 4'd0,
                               fill_valid, 1'b0);
                    count++;
                    fill_valid = next_index(fill_valid, fill, nx);
                    fill = nx;
                    if (fill_valid && fill == int'(cidx))
                        break;
                end
            end
        end
        push_entry(1'b0, 1'b0, frame, cidx, known, 1'b1);
        seen_entry      = 1'b1;
        last_real_known = known;
        last_index      = known ? cidx : 4'd0;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap(input bit enabled);
        int roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic string show_entry(input frame_entry_t e);
        return $sformatf("pad=%0b gap=%0b frame=%h idx=%0d valid=%0b pos=%0d last=%0b",
                         e.padded, e.gap_fill, e.frame, e.colour_index,
                         e.index_valid, e.position, e.last);
    endfunction

    // Send one entry; valid stays high when the next one follows at once.
    task automatic send_entry(input bit start, input bit pad, input bit [31:0] frame,
                              input bit known, input bit [3:0] cidx);
        int gap;
        gap = pick_gap(tx_idling);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {pad, start};
        s_tdata  <= {3'b000, cidx, known, frame};
        do
            @(posedge clk);
        while (!s_tready);
        predict_entry(start, pad, frame, known, cidx);
    endtask

    // One register write beat; the caller lowers valid after the last one.
    task automatic write_register(input logic [1:0] reg_index, input logic [2:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (reg_index)
            CFG_DEDUPE:   dedupe_on   = value[0];
            CFG_GAP_FILL: gap_fill_on = value[0];
            CFG_SYSTEM:   system_sel  = value;
            default:      ;
        endcase
    endtask

    task automatic write_config(input bit dedupe, input bit gap_fill, input bit [2:0] sys);
        write_register(CFG_DEDUPE, {2'b00, dedupe});
        write_register(CFG_GAP_FILL, {2'b00, gap_fill});
        write_register(CFG_SYSTEM, sys);
        cfg_valid <= 1'b0;
    endtask

    // Let every expected beat drain, then give a dropped entry time to clear.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_entries.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Settings after reset: every entry passes through; a pad slot comes out with frame and index cleared.
    task automatic test_pass_through();
        send_entry(1'b1, 1'b0, 32'h0000_0000, 1'b1, 4'd0);
        send_entry(1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 4'd15);
        send_entry(1'b0, 1'b1, 32'hA5A5_5A5A, 1'b1, 4'd9);
        send_entry(1'b0, 1'b0, 32'h1234_5678, 1'b1, 4'd15);
    endtask

    // Repeats are dropped unless a pad slot or an unknown index came between.
    task automatic test_dedupe();
        wait_idle();
        write_config(1'b1, 1'b0, SYS_PAL);
        send_entry(1'b1, 1'b0, 32'd100, 1'b1, 4'd3);
        send_entry(1'b0, 1'b0, 32'd101, 1'b1, 4'd3);
        send_entry(1'b0, 1'b1, 32'd0, 1'b0, 4'd0);
        send_entry(1'b0, 1'b0, 32'd102, 1'b1, 4'd3);
        send_entry(1'b0, 1'b0, 32'd103, 1'b0, 4'd3);
        send_entry(1'b0, 1'b0, 32'd104, 1'b1, 4'd3);
    endtask

    // PAL: short gaps, a wrap through the cycle and indices outside it.
    task automatic test_gap_fill_pal();
        wait_idle();
        write_config(1'b0, 1'b1, SYS_PAL);
        send_entry(1'b1, 1'b0, 32'd200, 1'b1, 4'd1);
        send_entry(1'b0, 1'b0, 32'd201, 1'b1, 4'd3);
        send_entry(1'b0, 1'b0, 32'd202, 1'b1, 4'd3);
        send_entry(1'b0, 1'b0, 32'd203, 1'b1, 4'd15);
        send_entry(1'b0, 1'b0, 32'd204, 1'b1, 4'd0);
    endtask

    // PAL-M on a fresh list.
    task automatic test_gap_fill_palm();
        wait_idle();
        write_config(1'b1, 1'b1, SYS_PALM);
        send_entry(1'b1, 1'b0, 32'd300, 1'b1, 4'd4);
        send_entry(1'b0, 1'b0, 32'd301, 1'b1, 4'd2);
    endtask

    // NTSC: two-phase cycle, then an index with no successor.
    task automatic test_gap_fill_ntsc();
        wait_idle();
        write_config(1'b0, 1'b1, SYS_NTSC);
        send_entry(1'b1, 1'b0, 32'd400, 1'b1, 4'd0);
        send_entry(1'b0, 1'b0, 32'd401, 1'b1, 4'd1);
        send_entry(1'b0, 1'b0, 32'd402, 1'b1, 4'd1);
        send_entry(1'b0, 1'b0, 32'd403, 1'b1, 4'd5);
        send_entry(1'b0, 1'b0, 32'd404, 1'b1, 4'd0);
    endtask

    // Other system fills with invalid pads; unused codes do no filling.
    task automatic test_other_systems();
        wait_idle();
        write_config(1'b0, 1'b1, SYS_OTHER);
        send_entry(1'b1, 1'b0, 32'd500, 1'b1, 4'd1);
        send_entry(1'b0, 1'b0, 32'd501, 1'b1, 4'd2);
        wait_idle();
        write_config(1'b1, 1'b1, 3'd7);
        send_entry(1'b1, 1'b0, 32'd600, 1'b1, 4'd0);
        send_entry(1'b0, 1'b0, 32'd601, 1'b1, 4'd2);
    endtask

    // Colour index runs that mostly follow the cycle, with faults mixed in.
    task automatic test_random_sequences();
        bit          dedupe;
        bit          gap_fill;
        bit [2:0]    sys;
        bit          start;
        bit          pad;
        bit          known;
        bit [3:0]    idx;
        bit [3:0]    sent_idx;
        bit [31:0]   frame;
        int          phase;
        int          n;
        int          run_left;
        int          roll;
        int          nx;
        idx   = 4'd0;
        frame = $urandom();
        for (phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            case (phase)
                0:       begin dedupe = 1'b1; gap_fill = 1'b1; sys = SYS_PAL;   end
                1:       begin dedupe = 1'b0; gap_fill = 1'b1; sys = SYS_NTSC;  end
                2:       begin dedupe = 1'b1; gap_fill = 1'b1; sys = SYS_PALM;  end
                3:       begin dedupe = 1'b0; gap_fill = 1'b1; sys = SYS_OTHER; end
                4:       begin dedupe = 1'b1; gap_fill = 1'b0; sys = 3'd5;      end
                default:
                begin
                    dedupe   = 1'($urandom_range(0, 1));
                    gap_fill = ($urandom_range(0, 4) != 0);
                    sys      = 3'($urandom_range(0, 7));
                end
            endcase
            write_config(dedupe, gap_fill, sys);
            // One phase runs at full rate on both sides, two others lose one side's idling.
            tx_idling = (phase != 1) && (phase != 6);
            rx_idling = (phase != 1) && (phase != 5);
            run_left = 0;
            for (n = 0; n < 44; n++)
            begin
                start = (run_left == 0);
                if (start)
                    run_left = $urandom_range(3, 16);
                run_left--;
                pad   = 1'b0;
                known = 1'b1;
                roll  = $urandom_range(0, 99);
                if (roll < 65)
                begin
                    if (next_index(1'b1, int'(idx), nx))
                        idx = nx[3:0];
                    else
                        idx = 4'($urandom_range(0, 3));
                end
                else if (roll < 86 && roll >= 75)
                    idx = 4'($urandom_range(0, 15));
                else if (roll >= 86 && roll < 93)
                    pad = 1'b1;
                else if (roll >= 93)
                    known = 1'b0;
                // Pad slots and unknown entries carry junk in the index bits.
                sent_idx = (pad || !known) ? 4'($urandom_range(0, 15)) : idx;
                if ($urandom_range(0, 3) == 0)
                    frame = $urandom();
                else
                    frame = frame + 32'd1;
                send_entry(start, pad, frame, known, sent_idx);
            end
        end
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    // Output side: ready with random stalls while idling is on.
    initial
    begin : ready_gen
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_idling && $urandom_range(0, 2) == 0)
                    hold = pick_gap(1'b1);
            end
        end
    end

    // Compare each output beat with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        frame_entry_t want;
        frame_entry_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.padded       = m_tuser[0];
            got.gap_fill     = m_tuser[1];
            got.frame        = m_tdata[31:0];
            got.colour_index = m_tdata[35:32];
            got.index_valid  = m_tdata[36];
            got.position     = m_tdata[68:37];
            got.last         = m_tlast;
            if (expected_entries.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %s", show_entry(got));
            end
            else
            begin
                want = expected_entries.pop_front();
                if (got.padded !== want.padded || got.gap_fill !== want.gap_fill ||
                    got.frame !== want.frame || got.colour_index !== want.colour_index ||
                    got.index_valid !== want.index_valid ||
                    got.position !== want.position || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat mismatch: expected %s, got %s",
                                 show_entry(want), show_entry(got));
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("colour_sequence_dedupe_and_gap_fill_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DEDUPE;
        cfg_data  <= 3'd0;
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        dedupe_on       = 1'b0;
        gap_fill_on     = 1'b0;
        system_sel      = SYS_UNKNOWN;
        seen_entry      = 1'b0;
        last_real_known = 1'b0;
        last_index      = 4'd0;
        out_count       = 32'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pass_through();
        test_dedupe();
        test_gap_fill_pal();
        test_gap_fill_palm();
        test_gap_fill_ntsc();
        test_other_systems();
        test_random_sequences();

        wait_idle();
        if (mismatches == 0)
            $display("colour_sequence_dedupe_and_gap_fill_tb: PASS");
        else
            $display("colour_sequence_dedupe_and_gap_fill_tb: FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/csdgf_pkg.sv
rtl/csdgf_datapath.sv
rtl/csdgf_ctrl.sv
rtl/colour_sequence_dedupe_and_gap_fill.sv
sim/colour_sequence_dedupe_and_gap_fill_tb.sv
